/* hdl/mfr_pkg.sv */
package mfr_pkg;

  localparam int FIELD_W = 32;
  localparam int WIDE_W  = 64;

  typedef struct packed {
    logic [FIELD_W-1:0] whole_part;
    logic [FIELD_W-1:0] numerator_in;
    logic [FIELD_W-1:0] denominator_in;
  } mfr_in_t;

  typedef struct packed {
    logic               status;
    logic [WIDE_W-1:0]  reduced_whole;
    logic [FIELD_W-1:0] reduced_remainder;
    logic [FIELD_W-1:0] reduced_denominator;
    logic [WIDE_W-1:0]  improper_numerator;
  } mfr_out_t;

  // which division the shared divider runs
  typedef enum logic [1:0] {
    DIV_IMP_DEN,
    DIV_DEN_G,
    DIV_REM_G,
    DIV_IMP_G
  } mfr_div_sel_t;

  typedef struct packed {
    logic         load;
    logic         mul;
    logic         add;
    logic         gcd_start;
    logic         div_start;
    logic         take_div;
    mfr_div_sel_t div_sel;
  } mfr_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic gcd_done;
  } mfr_stat_t;

endpackage

/* hdl/mixed_fraction_reducer.sv */
// work per transaction: four passes of the shared one-bit-per-cycle divider over 2 * IN_WIDTH bits,
// plus the binary gcd loop over the remainder and the denominator
// zero denominator: the check state goes straight to done, with status set and all fields zero
// throughput: one transaction at a time; the next is taken once the result is taken
// reset: synchronous active-low rst_n returns the controller to idle, no result pending
module mixed_fraction_reducer
  import mfr_pkg::*;
#(
  parameter int IN_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mfr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mfr_out_t out_data
);

  mfr_cmd_t  cmd;
  mfr_stat_t stat;

  mfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mfr_dp #(.W(IN_WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* hdl/mfr_div.sv */
module mfr_div #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [2*W-1:0] quo,
  output logic [W-1:0]   rem
);

  localparam int CNT_W = $clog2(2 * W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2*W-1:0]   quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[2*W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[2*W-2:0], ge};
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(2 * W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* hdl/mfr_dp.sv */
module mfr_dp
  import mfr_pkg::*;
#(
  parameter int W = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  mfr_cmd_t  cmd,
  input  mfr_in_t   in_data,
  output mfr_stat_t stat,
  output mfr_out_t  out_data
);

  localparam int K_W = $clog2(W + 1);

  logic [W-1:0]   whole_r, num_r, den_r;
  logic           err_r;
  logic [2*W-1:0] prod_r, imp_r, q_r, rnum_r;
  logic [W-1:0]   r_r, g_r, rden_r, rrem_r;
  logic [2*W-1:0] prod_full;

  logic [W-1:0]   a_r, a_nxt, b_r, b_nxt, g_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           gbusy_r, gbusy_nxt, gdone_r, gdone_nxt;

  logic [2*W-1:0] div_dividend, div_quo;
  logic [W-1:0]   div_divisor, div_rem;
  logic           div_done;

  assign prod_full = den_r * whole_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_IMP_DEN: begin
        div_dividend = imp_r;
        div_divisor  = den_r;
      end
      DIV_DEN_G: begin
        div_dividend = {{W{1'b0}}, den_r};
        div_divisor  = g_r;
      end
      DIV_REM_G: begin
        div_dividend = {{W{1'b0}}, r_r};
        div_divisor  = g_r;
      end
      default: begin
        div_dividend = imp_r;
        div_divisor  = g_r;
      end
    endcase
  end

  mfr_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // binary gcd of remainder and denominator, one step per cycle
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    gbusy_nxt = gbusy_r;
    gdone_nxt = 1'b0;
    if (cmd.gcd_start) begin
      a_nxt     = r_r;
      b_nxt     = den_r;
      k_nxt     = '0;
      gbusy_nxt = 1'b1;
    end else if (gbusy_r) begin
      if (a_r == '0) begin
        g_nxt     = b_r << k_r;
        gbusy_nxt = 1'b0;
        gdone_nxt = 1'b1;
      end else if (b_r == '0) begin
        g_nxt     = a_r << k_r;
        gbusy_nxt = 1'b0;
        gdone_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbusy_r <= 1'b0;
      gdone_r <= 1'b0;
    end else begin
      gbusy_r <= gbusy_nxt;
      gdone_r <= gdone_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
    if (cmd.load) begin
      whole_r <= in_data.whole_part[W-1:0];
      num_r   <= in_data.numerator_in[W-1:0];
      den_r   <= in_data.denominator_in[W-1:0];
      err_r   <= (in_data.denominator_in[W-1:0] == '0);
    end
    if (cmd.mul) prod_r <= prod_full;
    if (cmd.add) imp_r <= prod_r + {{W{1'b0}}, num_r};
    if (cmd.take_div) begin
      case (cmd.div_sel)
        DIV_IMP_DEN: begin
          q_r <= div_quo;
          r_r <= div_rem;
        end
        DIV_DEN_G: rden_r <= div_quo[W-1:0];
        DIV_REM_G: rrem_r <= div_quo[W-1:0];
        default:   rnum_r <= div_quo;
      endcase
    end
  end

  assign stat.den_zero = err_r;
  assign stat.div_done = div_done;
  assign stat.gcd_done = gdone_r;

  always_comb begin
    out_data.status = err_r;
    if (err_r) begin
      out_data.reduced_whole       = '0;
      out_data.reduced_remainder   = '0;
      out_data.reduced_denominator = '0;
      out_data.improper_numerator  = '0;
    end else begin
      out_data.reduced_whole       = WIDE_W'(q_r);
      out_data.reduced_remainder   = FIELD_W'(rrem_r);
      out_data.reduced_denominator = FIELD_W'(rden_r);
      out_data.improper_numerator  = WIDE_W'(rnum_r);
    end
  end

endmodule

/* hdl/mfr_ctrl.sv */
module mfr_ctrl
  import mfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  mfr_stat_t stat,
  output mfr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_ADD, S_D1S, S_D1, S_GS, S_G,
    S_D2S, S_D2, S_D3S, S_D3, S_D4S, S_D4, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_IMP_DEN;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.den_zero ? S_DONE : S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_D1S;
      end
      S_D1S: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_D1;
      end
      S_D1: begin
        if (stat.div_done) begin
          cmd.take_div = 1'b1;
          state_nxt    = S_GS;
        end
      end
      S_GS: begin
        cmd.gcd_start = 1'b1;
        state_nxt     = S_G;
      end
      S_G: begin
        if (stat.gcd_done) state_nxt = S_D2S;
      end
      S_D2S: begin
        cmd.div_sel   = DIV_DEN_G;
        cmd.div_start = 1'b1;
        state_nxt     = S_D2;
      end
      S_D2: begin
        cmd.div_sel = DIV_DEN_G;
        if (stat.div_done) begin
          cmd.take_div = 1'b1;
          state_nxt    = S_D3S;
        end
      end
      S_D3S: begin
        cmd.div_sel   = DIV_REM_G;
        cmd.div_start = 1'b1;
        state_nxt     = S_D3;
      end
      S_D3: begin
        cmd.div_sel = DIV_REM_G;
        if (stat.div_done) begin
          cmd.take_div = 1'b1;
          state_nxt    = S_D4S;
        end
      end
      S_D4S: begin
        cmd.div_sel   = DIV_IMP_G;
        cmd.div_start = 1'b1;
        state_nxt     = S_D4;
      end
      S_D4: begin
        cmd.div_sel = DIV_IMP_G;
        if (stat.div_done) begin
          cmd.take_div = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* hdl/mfr_checker.sv */
module mfr_checker
  import mfr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input mfr_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken during work");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.reduced_whole == '0 &&
      out_data.reduced_remainder == '0 && out_data.reduced_denominator == '0 &&
      out_data.improper_numerator == '0)
    else $error("error result with nonzero fields");

  a_proper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.status |->
      out_data.reduced_remainder < out_data.reduced_denominator)
    else $error("remainder not below denominator");

endmodule

bind mixed_fraction_reducer mfr_checker u_mfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/mixed_fraction_reducer_test.sv */
module mixed_fraction_reducer_test;
  import mfr_pkg::*;

  localparam int N_RANDOM = 1400;

  class fraction_scoreboard;
    mfr_out_t reduced_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function mfr_out_t reduce(mfr_in_t x);
      mfr_out_t r;
      logic [63:0] imp, den, a, b, g, rn;
      int shift;
      r = '0;
      den = {32'b0, x.denominator_in};
      if (den == 0) begin
        r.status = 1'b1;
        return r;
      end
      imp = {32'b0, x.numerator_in} + den * {32'b0, x.whole_part};
      a = imp;
      b = den;
      shift = 0;
      if (a == 0) g = b;
      else begin
        while (((a | b) & 1) == 0) begin
          a = a >> 1;
          b = b >> 1;
          shift++;
        end
        while ((a & 1) == 0) a = a >> 1;
        while (b != 0) begin
          while ((b & 1) == 0) b = b >> 1;
          if (a > b) begin
            g = a;
            a = b;
            b = g;
          end
          b = b - a;
        end
        g = a << shift;
      end
      rn = imp / g;
      den = den / g;
      r.reduced_whole = rn / den;
      r.reduced_remainder = 32'(rn % den);
      r.reduced_denominator = 32'(den);
      r.improper_numerator = rn;
      return r;
    endfunction

    function void note_input(mfr_in_t x);
      reduced_q.push_back(reduce(x));
    endfunction

    function void check_result(mfr_out_t y);
      mfr_out_t e;
      if (reduced_q.size() == 0) begin
        $error("unexpected transaction on output");
        errors++;
        return;
      end
      e = reduced_q.pop_front();
      if (y.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, y.status);
        errors++;
      end
      if (y.reduced_whole !== e.reduced_whole) begin
        $error("reduced_whole exp %0d got %0d", e.reduced_whole, y.reduced_whole);
        errors++;
      end
      if (y.reduced_remainder !== e.reduced_remainder) begin
        $error("reduced_remainder exp %0d got %0d", e.reduced_remainder, y.reduced_remainder);
        errors++;
      end
      if (y.reduced_denominator !== e.reduced_denominator) begin
        $error("reduced_denominator exp %0d got %0d", e.reduced_denominator,
               y.reduced_denominator);
        errors++;
      end
      if (y.improper_numerator !== e.improper_numerator) begin
        $error("improper_numerator exp %0d got %0d", e.improper_numerator,
               y.improper_numerator);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mfr_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mfr_out_t out_data;
  logic stim_done = 1'b0;
  logic hold_off = 1'b0;
  fraction_scoreboard sb = new();

  mixed_fraction_reducer dut (.*);

  always #10 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 400);
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'(0);
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 16));
      3: return 32'($urandom_range(1, 1000));
      4: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // valid is written blocking so back-to-back transactions never see two updates in one step
  task automatic send_fraction(logic [31:0] w, logic [31:0] n, logic [31:0] d);
    in_data <= '{whole_part: w, numerator_in: n, denominator_in: d};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random();
    logic [31:0] w, n, d, k;
    w = rand_field();
    n = rand_field();
    d = rand_field();
    // make a common factor likely
    if ($urandom_range(0, 2) == 0) begin
      k = $urandom_range(2, 60);
      n = n % 32'h0400_0000 * k;
      d = (d % 32'h0400_0000 | 1) * k;
    end
    if ($urandom_range(0, 19) == 0) d = 0;
    send_fraction(w, n, d);
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_off && $urandom_range(0, 3) != 0) out_ready <= 1'b1;
      else out_ready <= 1'b0;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  initial begin
    int cnt;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_fraction(0, 0, 0);
    send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_fraction(0, 0, 7);
    send_fraction(5, 0, 32'hFFFF_FFFF);
    send_fraction(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_fraction(1, 2, 4);
    send_fraction(3, 6, 9);
    send_fraction(0, 10, 4);
    send_fraction(0, 7, 1);
    send_fraction(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fraction(0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_fraction(12, 0, 0);
    send_fraction(0, 1, 32'hFFFF_FFFF);
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        cnt = 0;
        while (cnt < 600) begin
          @(posedge clk);
          cnt++;
        end
        hold_off = 1'b0;
      end
      repeat (4) send_random();
    join
    for (int i = 0; i < N_RANDOM; i++) begin
      repeat (gap_len()) @(negedge clk);
      send_random();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.reduced_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
